// File: rtl/core/dpq_pkg.sv
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared types, operation codes and sizes of the double-ended priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int ECNT_W   = 7;
	localparam int RES_W    = 1 + ECNT_W + VAL_W + VAL_W + 1 + 1;
	localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

	typedef logic signed [VAL_W-1:0] key_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [1:0]              op_t;

	localparam op_t OP_INSERT  = 2'd0;
	localparam op_t OP_DEL_MAX = 2'd1;
	localparam op_t OP_DEL_MIN = 2'd2;
	localparam op_t OP_CLEAR   = 2'd3;

	typedef struct packed {
		logic ins;
		logic shift;
	} dpq_ctl_t;

endpackage

// File: rtl/core/dpq_cell.sv
// ----------------------------------------------------------------------------
// dpq_cell
// One sorted cell: holds a key, opens a slot on insert, takes the upper
// neighbor's key when the front of the chain is removed.
// ----------------------------------------------------------------------------
module dpq_cell import dpq_pkg::*; (
	input  logic     clk,
	input  dpq_ctl_t ctl,
	input  logic     descend,
	input  logic     occ,
	input  key_t     value,
	input  key_t     prev_key,
	input  logic     prev_take,
	input  key_t     next_key,
	output key_t     key,
	output logic     take,
	output key_t     key_d
);

	key_t key_q;

	assign key  = key_q;
	assign take = !occ || (descend ? (key_q < value) : (key_q > value));

	always_comb begin
		key_d = key_q;
		if (ctl.ins) begin
			if (take) begin
				key_d = prev_take ? prev_key : value;
			end
		end else if (ctl.shift) begin
			key_d = next_key;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

// File: rtl/core/dpq_chain.sv
// ----------------------------------------------------------------------------
// dpq_chain
// Row of sorted cells, front entry at cell zero; ascending or descending.
// ----------------------------------------------------------------------------
module dpq_chain import dpq_pkg::*; (
	input  logic     clk,
	input  dpq_ctl_t ctl,
	input  logic     descend,
	input  key_t     value,
	input  cnt_t     count,
	output key_t     front_d
);

	key_t key_a   [CAPACITY];
	key_t key_d_a [CAPACITY];
	logic take_a  [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		key_t prev_key;
		logic prev_take;
		key_t next_key;

		if (i == 0) begin : g_first
			assign prev_key  = value;
			assign prev_take = 1'b0;
		end else begin : g_mid
			assign prev_key  = key_a[i-1];
			assign prev_take = take_a[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_key = key_a[i];
		end else begin : g_inner
			assign next_key = key_a[i+1];
		end

		dpq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.descend   (descend),
			.occ       (CNT_W'(i) < count),
			.value     (value),
			.prev_key  (prev_key),
			.prev_take (prev_take),
			.next_key  (next_key),
			.key       (key_a[i]),
			.take      (take_a[i]),
			.key_d     (key_d_a[i])
		);
	end

	assign front_d = key_d_a[0];

endmodule

// File: rtl/core/double_ended_priority_queue.sv
// The result of a transfer is registered in m_data_q, or in the skid stage on a stall.
// Throughput: one item per cycle while s_tready is high; all cells of both chains
// compare, and the chains that the operation uses move, in the cycle of the transfer.
// Reset: clears the count and the handshake state; cell contents stay as they are
// and are never shown before they are written.
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded min/max queue built from an ascending and a descending cell chain.
// ----------------------------------------------------------------------------
module double_ended_priority_queue import dpq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,   // value
	input  logic [1:0]       s_tuser,   // operation
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // is_empty, entry_count, largest, smallest,
	                                    // insert_dropped, delete_ignored, zero pad
);

	cnt_t             count_q;
	cnt_t             count_d;
	dpq_ctl_t         asc_ctl;
	dpq_ctl_t         desc_ctl;
	key_t             value;
	key_t             min_d;
	key_t             max_d;
	logic             dropped;
	logic             ignored;
	logic             accept;
	logic             empty_d;
	logic [OUT_W-1:0] res;
	logic [OUT_W-1:0] m_data_q;
	logic [OUT_W-1:0] skid_data_q;
	logic             m_valid_q;
	logic             skid_valid_q;

	assign value    = key_t'(s_tdata);
	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		count_d  = count_q;
		asc_ctl  = '0;
		desc_ctl = '0;
		dropped  = 1'b0;
		ignored  = 1'b0;
		unique case (s_tuser)
			OP_INSERT: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					dropped = 1'b1;
				end else begin
					asc_ctl.ins  = accept;
					desc_ctl.ins = accept;
					count_d      = count_q + 1'b1;
				end
			end
			OP_DEL_MAX: begin
				if (count_q == '0) begin
					ignored = 1'b1;
				end else begin
					desc_ctl.shift = accept;
					count_d        = count_q - 1'b1;
				end
			end
			OP_DEL_MIN: begin
				if (count_q == '0) begin
					ignored = 1'b1;
				end else begin
					asc_ctl.shift = accept;
					count_d       = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	dpq_chain u_asc (
		.clk     (clk),
		.ctl     (asc_ctl),
		.descend (1'b0),
		.value   (value),
		.count   (count_q),
		.front_d (min_d)
	);

	dpq_chain u_desc (
		.clk     (clk),
		.ctl     (desc_ctl),
		.descend (1'b1),
		.value   (value),
		.count   (count_q),
		.front_d (max_d)
	);

	assign empty_d = (count_d == '0);
	assign res = OUT_W'({ignored, dropped,
	                     (empty_d ? key_t'(0) : min_d),
	                     (empty_d ? key_t'(0) : max_d),
	                     ECNT_W'(count_d), empty_d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_tready || !m_valid_q) begin
			if (skid_valid_q) begin
				m_valid_q    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				m_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !m_valid_q) begin
			m_data_q <= skid_valid_q ? skid_data_q : res;
		end else if (accept) begin
			skid_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> m_valid_q)
		else $error("skid holds data while output is empty");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[71:8] == '0))
		else $error("empty result with nonzero extremes");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[72] && m_tdata[73]))
		else $error("both refusal flags set");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser != OP_CLEAR) |=>
			(count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
			 count_q == $past(count_q) - 1'b1))
		else $error("count moved by more than one");
`endif

endmodule
